// File: src/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Shared sizes, codes and control/status types of the charge space fusion
// block.
// ----------------------------------------------------------------------------
package csf_pkg;

    // sizes of the sector lists and of the fused table
    localparam int MAX_SECTORS = 8;
    localparam int MAX_FUSED   = 64;
    localparam int CHARGE_BITS = 8;
    localparam int DIM_BITS    = 16;

    // derived widths
    localparam int OPC_W       = 2;
    localparam int SUM_BITS    = CHARGE_BITS + 1;
    localparam int PROD_BITS   = 2 * DIM_BITS;
    localparam int ACC_BITS    = 38;
    localparam int SEC_IDX_W   = $clog2(MAX_SECTORS);
    localparam int SEC_CNT_W   = $clog2(MAX_SECTORS + 1);
    localparam int FUSE_IDX_W  = $clog2(MAX_FUSED);
    localparam int FUSE_CNT_W  = $clog2(MAX_FUSED + 1);
    localparam int EMIT_CNT_W  = (FUSE_CNT_W > SEC_CNT_W) ? FUSE_CNT_W : SEC_CNT_W;
    localparam int LIST_TOT_W  = DIM_BITS + SEC_CNT_W;
    localparam int IDX_DEPTH   = 2 ** SUM_BITS;

    // command opcodes
    localparam logic [OPC_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OPC_W-1:0] OP_PRODUCT     = 2'd2;

    // source of the result items of a run
    localparam logic [1:0] SRC_FUSED  = 2'd0;
    localparam logic [1:0] SRC_FIRST  = 2'd1;
    localparam logic [1:0] SRC_SECOND = 2'd2;
    localparam logic [1:0] SRC_EMPTY  = 2'd3;

    // one entry of the fused table
    typedef struct packed {
        logic [SUM_BITS-1:0] charge;
        logic [ACC_BITS-1:0] dim;
    } t_fuse_ent;

    // controller to datapath
    typedef struct packed {
        logic       clr_step;
        logic       load_first;
        logic       load_second;
        logic       start;
        logic       calc;
        logic       idx_rd;
        logic       fuse_rd;
        logic       rd_emit;
        logic       update;
        logic       out_load;
        logic [1:0] out_src;
        logic       clear_lists;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic first_empty;
        logic second_empty;
        logic pair_last;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

// File: src/csf_if.sv
// ----------------------------------------------------------------------------
// csf_in_if / csf_out_if
// Valid/ready channels of the charge space fusion block: command beats in,
// result sector beats out.
// ----------------------------------------------------------------------------
interface csf_in_if;
    import csf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [OPC_W-1:0]              opcode;
    logic signed [CHARGE_BITS-1:0] charge;
    logic [DIM_BITS-1:0]           degeneracy;

    modport source (output valid, output opcode, output charge, output degeneracy,
                    input ready);
    modport sink   (input valid, input opcode, input charge, input degeneracy,
                    output ready);
endinterface

interface csf_out_if;
    import csf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] sum_charge;
    logic [ACC_BITS-1:0]        sector_dim;
    logic [ACC_BITS-1:0]        total_dim;
    logic                       last;
    logic                       empty_res;

    modport source (output valid, output sum_charge, output sector_dim,
                    output total_dim, output last, output empty_res, input ready);
    modport sink   (input valid, input sum_charge, input sector_dim,
                    input total_dim, input last, input empty_res, output ready);
endinterface

// File: src/csf_ctrl.sv
// ----------------------------------------------------------------------------
// csf_ctrl
// Controller of the charge space fusion block: takes command beats, walks the
// sector pairs and steps the result emission.
// ----------------------------------------------------------------------------
module csf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csf_in_if.sink        i_in,
    output csf_pkg::t_cmd o_cmd,
    input  csf_pkg::t_sts i_sts
);
    import csf_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CALC  = 4'd2;
    localparam logic [3:0] ST_LOOK  = 4'd3;
    localparam logic [3:0] ST_FETCH = 4'd4;
    localparam logic [3:0] ST_UPD   = 4'd5;
    localparam logic [3:0] ST_ERD   = 4'd6;
    localparam logic [3:0] ST_EOUT  = 4'd7;
    localparam logic [3:0] ST_LOUT  = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_src, n_src;
    t_cmd       cmd;
    logic       in_ready;

    // state and run source
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_src   <= SRC_EMPTY;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        cmd         = '0;
        cmd.out_src = r_src;
        in_ready    = 1'b0;
        unique case (r_state) inside
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    unique case (i_in.opcode)
                        OP_LOAD_FIRST:  cmd.load_first  = 1'b1;
                        OP_LOAD_SECOND: cmd.load_second = 1'b1;
                        OP_PRODUCT: begin
                            cmd.start = 1'b1;
                            if (i_sts.first_empty && i_sts.second_empty) begin
                                n_src   = SRC_EMPTY;
                                n_state = ST_LOUT;
                            end else if (i_sts.first_empty) begin
                                n_src   = SRC_SECOND;
                                n_state = ST_LOUT;
                            end else if (i_sts.second_empty) begin
                                n_src   = SRC_FIRST;
                                n_state = ST_LOUT;
                            end else begin
                                n_src   = SRC_FUSED;
                                n_state = ST_CALC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CALC: begin
                cmd.calc = 1'b1;
                n_state  = ST_LOOK;
            end
            ST_LOOK: begin
                cmd.idx_rd = 1'b1;
                n_state    = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fuse_rd = 1'b1;
                n_state     = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                n_state    = i_sts.pair_last ? ST_ERD : ST_CALC;
            end
            ST_ERD: begin
                cmd.fuse_rd = 1'b1;
                cmd.rd_emit = 1'b1;
                n_state     = ST_EOUT;
            end
            ST_EOUT, ST_LOUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (i_sts.emit_last) begin
                        cmd.clear_lists = 1'b1;
                        n_state         = ST_IDLE;
                    end else if (r_state == ST_EOUT) begin
                        n_state = ST_ERD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd      = cmd;
    assign i_in.ready = in_ready;

endmodule

// File: src/csf_dp.sv
// ----------------------------------------------------------------------------
// csf_dp
// Datapath of the charge space fusion block: sector lists, pair multiplier,
// charge-to-slot index memory, fused table memory and the output register.
// ----------------------------------------------------------------------------
module csf_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [csf_pkg::CHARGE_BITS-1:0] i_charge,
    input  logic [csf_pkg::DIM_BITS-1:0]           i_degeneracy,
    input  csf_pkg::t_cmd                          i_cmd,
    output csf_pkg::t_sts                          o_sts,
    csf_out_if.source                              o_res
);
    import csf_pkg::*;

    // sector lists
    logic [CHARGE_BITS-1:0] r_first_ch  [MAX_SECTORS];
    logic [DIM_BITS-1:0]    r_first_dim [MAX_SECTORS];
    logic [CHARGE_BITS-1:0] r_second_ch [MAX_SECTORS];
    logic [DIM_BITS-1:0]    r_second_dim[MAX_SECTORS];
    logic [SEC_CNT_W-1:0]   r_first_cnt, r_second_cnt;
    logic [LIST_TOT_W-1:0]  r_first_tot, r_second_tot;

    // walk counters
    logic [SEC_IDX_W-1:0]   r_i, r_j;
    logic [EMIT_CNT_W-1:0]  r_k;
    logic [SUM_BITS-1:0]    r_clr_addr;

    // pair operands
    logic [SUM_BITS-1:0]    r_sum;
    logic [PROD_BITS-1:0]   r_prod;

    // memories and their read registers
    logic [FUSE_IDX_W-1:0]  m_idx [IDX_DEPTH];
    t_fuse_ent              m_fuse[MAX_FUSED];
    logic [FUSE_IDX_W-1:0]  r_idx_q;
    t_fuse_ent              r_fuse_q;
    logic [FUSE_CNT_W-1:0]  r_fcnt;
    logic [ACC_BITS-1:0]    r_total;

    // output register
    logic                   r_out_valid;
    logic [SUM_BITS-1:0]    r_out_charge;
    logic [ACC_BITS-1:0]    r_out_dim;
    logic [ACC_BITS-1:0]    r_out_total;
    logic                   r_out_last;
    logic                   r_out_empty;

    logic [SEC_IDX_W-1:0]   f_addr, s_addr;
    logic [CHARGE_BITS-1:0] f_ch, s_ch;
    logic [DIM_BITS-1:0]    f_dim, s_dim;
    logic                   first_full, second_full;
    logic [SEC_CNT_W-1:0]   i_next, j_next;
    logic [EMIT_CNT_W-1:0]  k_next;
    logic                   hit, room, append, fuse_we;
    logic [FUSE_IDX_W-1:0]  fuse_waddr, fuse_raddr;
    t_fuse_ent              fuse_wdata;
    logic                   idx_we;
    logic [SUM_BITS-1:0]    idx_waddr;
    logic [FUSE_IDX_W-1:0]  idx_wdata;
    logic                   emit_last;

    assign first_full  = (r_first_cnt  == SEC_CNT_W'(MAX_SECTORS));
    assign second_full = (r_second_cnt == SEC_CNT_W'(MAX_SECTORS));

    // list payload writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first && !first_full) begin
            r_first_ch [r_first_cnt[SEC_IDX_W-1:0]] <= i_charge;
            r_first_dim[r_first_cnt[SEC_IDX_W-1:0]] <= i_degeneracy;
        end
        if (i_cmd.load_second && !second_full) begin
            r_second_ch [r_second_cnt[SEC_IDX_W-1:0]] <= i_charge;
            r_second_dim[r_second_cnt[SEC_IDX_W-1:0]] <= i_degeneracy;
        end
    end

    // list counts and running degeneracy totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_lists) begin
            r_first_cnt  <= '0;
            r_first_tot  <= '0;
            r_second_cnt <= '0;
            r_second_tot <= '0;
        end else begin
            if (i_cmd.load_first && !first_full) begin
                r_first_cnt <= r_first_cnt + SEC_CNT_W'(1);
                r_first_tot <= r_first_tot + LIST_TOT_W'(i_degeneracy);
            end
            if (i_cmd.load_second && !second_full) begin
                r_second_cnt <= r_second_cnt + SEC_CNT_W'(1);
                r_second_tot <= r_second_tot + LIST_TOT_W'(i_degeneracy);
            end
        end
    end

    // list reads: pair walk or plain emission
    assign f_addr = i_cmd.calc ? r_i : r_k[SEC_IDX_W-1:0];
    assign s_addr = i_cmd.calc ? r_j : r_k[SEC_IDX_W-1:0];
    assign f_ch   = r_first_ch[f_addr];
    assign f_dim  = r_first_dim[f_addr];
    assign s_ch   = r_second_ch[s_addr];
    assign s_dim  = r_second_dim[s_addr];

    // charge sum and degeneracy product of one pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_sum  <= {f_ch[CHARGE_BITS-1], f_ch} + {s_ch[CHARGE_BITS-1], s_ch};
            r_prod <= PROD_BITS'(f_dim) * PROD_BITS'(s_dim);
        end
    end

    // slot lookup is trusted only if the slot is live and holds the same charge
    assign hit    = (FUSE_CNT_W'(r_idx_q) < r_fcnt) && (r_fuse_q.charge == r_sum);
    assign room   = (r_fcnt < FUSE_CNT_W'(MAX_FUSED));
    assign append = i_cmd.update && !hit && room;

    assign fuse_we          = (i_cmd.update && hit) || append;
    assign fuse_waddr       = hit ? r_idx_q : r_fcnt[FUSE_IDX_W-1:0];
    assign fuse_wdata.charge = r_sum;
    assign fuse_wdata.dim    = hit ? (r_fuse_q.dim + ACC_BITS'(r_prod))
                                   : ACC_BITS'(r_prod);
    assign fuse_raddr       = i_cmd.rd_emit ? r_k[FUSE_IDX_W-1:0] : r_idx_q;

    assign idx_we    = i_cmd.clr_step || append;
    assign idx_waddr = i_cmd.clr_step ? r_clr_addr : r_sum;
    assign idx_wdata = i_cmd.clr_step ? '0 : r_fcnt[FUSE_IDX_W-1:0];

    // charge-to-slot index memory
    always_ff @(posedge i_clk) begin
        if (idx_we) begin
            m_idx[idx_waddr] <= idx_wdata;
        end
        if (i_cmd.idx_rd) begin
            r_idx_q <= m_idx[r_sum];
        end
    end

    // fused table memory
    always_ff @(posedge i_clk) begin
        if (fuse_we) begin
            m_fuse[fuse_waddr] <= fuse_wdata;
        end
        if (i_cmd.fuse_rd) begin
            r_fuse_q <= m_fuse[fuse_raddr];
        end
    end

    assign i_next = SEC_CNT_W'(r_i) + SEC_CNT_W'(1);
    assign j_next = SEC_CNT_W'(r_j) + SEC_CNT_W'(1);
    assign k_next = r_k + EMIT_CNT_W'(1);

    // walk counters, fill count and grand total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_fcnt     <= '0;
            r_total    <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + SUM_BITS'(1);
            end
            if (i_cmd.start) begin
                r_i     <= '0;
                r_j     <= '0;
                r_k     <= '0;
                r_fcnt  <= '0;
                r_total <= '0;
            end else begin
                if (i_cmd.update) begin
                    if (j_next == r_second_cnt) begin
                        r_j <= '0;
                        r_i <= i_next[SEC_IDX_W-1:0];
                    end else begin
                        r_j <= j_next[SEC_IDX_W-1:0];
                    end
                    if (hit || room) begin
                        r_total <= r_total + ACC_BITS'(r_prod);
                    end
                    if (append) begin
                        r_fcnt <= r_fcnt + FUSE_CNT_W'(1);
                    end
                end
                if (i_cmd.out_load) begin
                    r_k <= k_next;
                end
            end
        end
    end

    // end of the run for the selected source
    always_comb begin
        unique case (i_cmd.out_src)
            SRC_FUSED:  emit_last = (k_next == EMIT_CNT_W'(r_fcnt));
            SRC_FIRST:  emit_last = (k_next == EMIT_CNT_W'(r_first_cnt));
            SRC_SECOND: emit_last = (k_next == EMIT_CNT_W'(r_second_cnt));
            default:    emit_last = 1'b1;
        endcase
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_src)
                SRC_FUSED: begin
                    r_out_charge <= r_fuse_q.charge;
                    r_out_dim    <= r_fuse_q.dim;
                    r_out_total  <= r_total;
                    r_out_last   <= emit_last;
                    r_out_empty  <= 1'b0;
                end
                SRC_FIRST: begin
                    r_out_charge <= {f_ch[CHARGE_BITS-1], f_ch};
                    r_out_dim    <= ACC_BITS'(f_dim);
                    r_out_total  <= ACC_BITS'(r_first_tot);
                    r_out_last   <= emit_last;
                    r_out_empty  <= 1'b0;
                end
                SRC_SECOND: begin
                    r_out_charge <= {s_ch[CHARGE_BITS-1], s_ch};
                    r_out_dim    <= ACC_BITS'(s_dim);
                    r_out_total  <= ACC_BITS'(r_second_tot);
                    r_out_last   <= emit_last;
                    r_out_empty  <= 1'b0;
                end
                default: begin
                    r_out_charge <= '0;
                    r_out_dim    <= '0;
                    r_out_total  <= '0;
                    r_out_last   <= 1'b0;
                    r_out_empty  <= 1'b1;
                end
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.sum_charge = r_out_charge;
    assign o_res.sector_dim = r_out_dim;
    assign o_res.total_dim  = r_out_total;
    assign o_res.last       = r_out_last;
    assign o_res.empty_res  = r_out_empty;

    // status back to the controller
    assign o_sts.clr_done     = &r_clr_addr;
    assign o_sts.first_empty  = (r_first_cnt == '0);
    assign o_sts.second_empty = (r_second_cnt == '0);
    assign o_sts.pair_last    = (i_next == r_first_cnt) && (j_next == r_second_cnt);
    assign o_sts.emit_last    = emit_last;
    assign o_sts.out_free     = !r_out_valid || o_res.ready;

endmodule

// File: src/charge_space_fusion.sv
// ----------------------------------------------------------------------------
// charge_space_fusion
// Fuses two U1 charge spaces loaded sector by sector and streams the fused
// sectors in order of first appearance.
// ----------------------------------------------------------------------------
// A product beat over two non-empty lists walks every sector pair through
// the steps sum and multiply, slot lookup in the charge index memory, fused
// table read, and accumulate or append. Each fused sector is then emitted
// by a read through the single fused table read port and an output load,
// and the emission waits whenever the result side stalls. With one list
// empty the other list streams out at one sector a cycle while the result
// side does not stall; with both empty one beat with empty_res set comes
// out. After reset the block clears the charge index memory and takes no
// command beat during that pass. The next command beat is taken while the
// last result beat of a run still waits in the output register.
module charge_space_fusion (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csf_in_if.sink    i_in,
    csf_out_if.source o_res
);
    import csf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // command sequencing
    csf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // storage, arithmetic and result register
    csf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_charge     (i_in.charge),
        .i_degeneracy (i_in.degeneracy),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_res        (o_res)
    );

endmodule
